@@ rtl/core/etcb_pkg.sv @@
// ----------------------------------------------------------------------------
// etcb_pkg: shared constants, types and rounding helpers
// Fixed-point formats, reduction constants and the Q30 rounding functions
// used by the angle-to-basis pipeline.
// ----------------------------------------------------------------------------
package etcb_pkg;

  // Angle input: 2^-ANG_FRAC degree units. Output: OUT_FRAC fraction bits.
  localparam int ANG_FRAC  = 6;
  localparam int OUT_FRAC  = 14;

  // Modulo-360 reduction
  localparam int FULL_TURN = 360 << ANG_FRAC;
  localparam int QUARTER   = 90 << ANG_FRAC;
  localparam int ANG_OFF   = ((32768 + FULL_TURN - 1) / FULL_TURN) * FULL_TURN;
  localparam int RED_W     = $clog2(32768 + ANG_OFF);
  localparam int RED_R     = (1 << RED_W) / FULL_TURN;
  localparam int M_W       = $clog2(QUARTER);

  // Degree to radian scaling, pi in Q44 split into two 23-bit halves
  localparam logic [45:0] PI44  = 46'h3243F6A8885A;
  localparam logic [22:0] PI_HI = PI44[45:23];
  localparam logic [22:0] PI_LO = PI44[22:0];
  localparam int XN_SH = 14 + ANG_FRAC;
  localparam int HP_W  = M_W + 23;
  localparam int P_W   = M_W + 47;
  localparam int N_W   = 39;

  // Division by 180 in two digits of 16 bits
  localparam int DIV180 = 180;
  localparam int R1     = (1 << 23) / DIV180;
  localparam int R2     = (1 << 24) / DIV180;

  // Taylor series
  localparam int SER_TERMS = 8;
  localparam int SC_LAT    = 12 + 3 * SER_TERMS;

  localparam int SC_W   = 34;
  localparam int PR_W   = 2 * SC_W;
  localparam int WIDE_W = 70;

  typedef logic signed [SC_W-1:0]   q30_t;
  typedef logic signed [PR_W-1:0]   prod_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

  // Divide by 2^sh, rounding half away from zero
  function automatic wide_t rshift(input wide_t v, input int sh);
    logic              neg;
    logic [WIDE_W-1:0] mag;
    logic [WIDE_W-1:0] half;
    neg  = v[WIDE_W-1];
    mag  = neg ? WIDE_W'(-v) : WIDE_W'(v);
    half = (WIDE_W'(1) << sh) >> 1;
    mag  = (mag + half) >> sh;
    return neg ? wide_t'(-mag) : wide_t'(mag);
  endfunction

  // Round to the output format, saturate to +/-1.0, keep 16 bits
  function automatic logic [15:0] to_out(input wide_t v, input int frac);
    wide_t r;
    wide_t lim;
    lim = wide_t'(1) <<< OUT_FRAC;
    r   = rshift(v, frac - OUT_FRAC);
    if (r > lim) begin
      r = lim;
    end else if (r < -lim) begin
      r = -lim;
    end
    return r[15:0];
  endfunction

endpackage

@@ rtl/core/etcb_if.sv @@
// ----------------------------------------------------------------------------
// etcb_if: valid/ready channels of the angle-to-basis block
// Angle triple in, nine basis vector components out.
// ----------------------------------------------------------------------------
interface etcb_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] yaw_angle;
  logic signed [15:0] pitch_angle;
  logic signed [15:0] roll_angle;

  modport source (output valid, yaw_angle, pitch_angle, roll_angle, input ready);
  modport sink (input valid, yaw_angle, pitch_angle, roll_angle, output ready);
endinterface

interface etcb_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] forward_x;
  logic signed [15:0] forward_y;
  logic signed [15:0] forward_z;
  logic signed [15:0] up_x;
  logic signed [15:0] up_y;
  logic signed [15:0] up_z;
  logic signed [15:0] right_x;
  logic signed [15:0] right_y;
  logic signed [15:0] right_z;

  modport source (output valid, forward_x, forward_y, forward_z, up_x, up_y, up_z,
                  right_x, right_y, right_z, input ready);
  modport sink (input valid, forward_x, forward_y, forward_z, up_x, up_y, up_z,
                right_x, right_y, right_z, output ready);
endinterface

@@ rtl/core/etcb_sincos.sv @@
// ----------------------------------------------------------------------------
// etcb_sincos: pipelined sine and cosine of a fixed-point degree angle
// Reduces mod 360, scales to radians, runs an 8-term Taylor series one
// term per three stages and maps the quadrant. Q30 results.
// ----------------------------------------------------------------------------
module etcb_sincos (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] angle,
  output etcb_pkg::q30_t     sin_q,
  output etcb_pkg::q30_t     cos_q
);

  localparam int RW   = etcb_pkg::RED_W;
  localparam int RP_W = 2 * RW;
  localparam int MW   = etcb_pkg::M_W;
  localparam int HW   = etcb_pkg::HP_W;
  localparam int PW   = etcb_pkg::P_W;
  localparam int NW   = etcb_pkg::N_W;
  localparam int SC   = etcb_pkg::SC_W;
  localparam int NT   = etcb_pkg::SER_TERMS;
  localparam int QD   = etcb_pkg::SC_LAT - 3;

  localparam logic [PW-1:0] XN_HALF = PW'(90) << etcb_pkg::XN_SH;

  // Stage 1: offset to non-negative, estimate quotient by full turn
  logic [RW-1:0]   red_sum;
  logic [RP_W-1:0] red_prod;
  logic [RW-1:0]   s1_v;
  logic [RW-1:0]   s1_q;

  assign red_sum  = RW'(int'(angle) + etcb_pkg::ANG_OFF);
  assign red_prod = RP_W'(red_sum) * RP_W'(etcb_pkg::RED_R);

  always_ff @(posedge clk) begin
    if (en) begin
      s1_v <= red_sum;
      s1_q <= red_prod[RP_W-1:RW];
    end
  end

  // Stage 2: remainder with one correction step
  logic [RW-1:0] red_rem;
  logic [RW-1:0] s2_r;

  always_comb begin
    red_rem = s1_v - RW'(RP_W'(s1_q) * RP_W'(etcb_pkg::FULL_TURN));
    if (red_rem >= RW'(etcb_pkg::FULL_TURN)) begin
      red_rem = red_rem - RW'(etcb_pkg::FULL_TURN);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r <= red_rem;
    end
  end

  // Stage 3: quadrant and angle within the quadrant
  logic [1:0]    quad_c;
  logic [RW-1:0] quad_base;
  logic [MW-1:0] s3_m;
  logic [1:0]    quad_d [QD];

  always_comb begin
    if (s2_r >= RW'(3 * etcb_pkg::QUARTER)) begin
      quad_c    = 2'd3;
      quad_base = RW'(3 * etcb_pkg::QUARTER);
    end else if (s2_r >= RW'(2 * etcb_pkg::QUARTER)) begin
      quad_c    = 2'd2;
      quad_base = RW'(2 * etcb_pkg::QUARTER);
    end else if (s2_r >= RW'(etcb_pkg::QUARTER)) begin
      quad_c    = 2'd1;
      quad_base = RW'(etcb_pkg::QUARTER);
    end else begin
      quad_c    = 2'd0;
      quad_base = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_m      <= MW'(s2_r - quad_base);
      quad_d[0] <= quad_c;
      for (int i = 1; i < QD; i++) begin
        quad_d[i] <= quad_d[i-1];
      end
    end
  end

  // Stage 4: m * pi as two partial products
  logic [HW-1:0] s4_hi;
  logic [HW-1:0] s4_lo;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_hi <= HW'(s3_m) * HW'(etcb_pkg::PI_HI);
      s4_lo <= HW'(s3_m) * HW'(etcb_pkg::PI_LO);
    end
  end

  // Stage 5: add halves plus rounding term, drop the binary part of 180 << 20
  logic [PW-1:0] pi_sum;
  logic [NW-1:0] s5_n;

  assign pi_sum = PW'({s4_hi, 23'd0}) + PW'(s4_lo) + XN_HALF;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_n <= NW'(pi_sum >> etcb_pkg::XN_SH);
    end
  end

  // Stage 6: upper digit of the divide by 180, reciprocal estimate
  logic [38:0] d1_prod;
  logic [22:0] s6_c1;
  logic [15:0] s6_lo;
  logic [15:0] s6_q1;

  assign d1_prod = 39'(s5_n[NW-1:16]) * 39'(etcb_pkg::R1);

  always_ff @(posedge clk) begin
    if (en) begin
      s6_c1 <= s5_n[NW-1:16];
      s6_lo <= s5_n[15:0];
      s6_q1 <= d1_prod[38:23];
    end
  end

  // Stage 7: upper digit correction
  logic [22:0] d1_rem;
  logic [15:0] s7_q1;
  logic [7:0]  s7_r1;
  logic [15:0] s7_lo;

  assign d1_rem = s6_c1 - 23'(24'(s6_q1) * 24'(etcb_pkg::DIV180));

  always_ff @(posedge clk) begin
    if (en) begin
      s7_lo <= s6_lo;
      if (d1_rem >= 23'(etcb_pkg::DIV180)) begin
        s7_q1 <= s6_q1 + 16'd1;
        s7_r1 <= 8'(d1_rem - 23'(etcb_pkg::DIV180));
      end else begin
        s7_q1 <= s6_q1;
        s7_r1 <= 8'(d1_rem);
      end
    end
  end

  // Stage 8: lower digit estimate
  logic [23:0] d2_num;
  logic [40:0] d2_prod;
  logic [23:0] s8_c2;
  logic [15:0] s8_q2;
  logic [15:0] s8_q1;

  assign d2_num  = {s7_r1, s7_lo};
  assign d2_prod = 41'(d2_num) * 41'(etcb_pkg::R2);

  always_ff @(posedge clk) begin
    if (en) begin
      s8_c2 <= d2_num;
      s8_q2 <= d2_prod[39:24];
      s8_q1 <= s7_q1;
    end
  end

  // Stage 9: lower digit correction, radians in Q30
  logic [23:0] d2_rem;
  logic [15:0] d2_q;
  logic [31:0] s9_x;

  assign d2_rem = s8_c2 - 24'(s8_q2 * 24'(etcb_pkg::DIV180));
  assign d2_q   = (d2_rem >= 24'(etcb_pkg::DIV180)) ? s8_q2 + 16'd1 : s8_q2;

  always_ff @(posedge clk) begin
    if (en) begin
      s9_x <= {s8_q1, d2_q};
    end
  end

  // Stage 10: x squared
  logic [63:0] s10_xx;
  logic [31:0] s10_x;

  always_ff @(posedge clk) begin
    if (en) begin
      s10_xx <= 64'(s9_x) * 64'(s9_x);
      s10_x  <= s9_x;
    end
  end

  // Stage 11: x^2 back to Q30, series seeds
  logic [31:0] s11_x;
  logic [31:0] s11_x2;

  always_ff @(posedge clk) begin
    if (en) begin
      s11_x  <= s10_x;
      s11_x2 <= 32'((s10_xx + (64'd1 << 29)) >> 30);
    end
  end

  // Series: three stages per term (product, reciprocal, correct + accumulate)
  logic [31:0] ts_k [1:NT];
  logic [31:0] tc_k [1:NT];
  logic [31:0] x2_k [1:NT];
  etcb_pkg::q30_t s_k [1:NT];
  etcb_pkg::q30_t c_k [1:NT];

  for (genvar k = 1; k <= NT; k++) begin : g_term
    localparam int NS = 2 * k;
    localparam int NC = 2 * k - 1;
    localparam int DS = NS * (NS + 1);
    localparam int DC = NC * (NC + 1);
    localparam logic [31:0] RS = 32'((64'd1 << 32) / DS);
    localparam logic [31:0] RC = 32'((64'd1 << 32) / DC);

    logic [31:0]    ts_i;
    logic [31:0]    tc_i;
    logic [31:0]    x2_i;
    etcb_pkg::q30_t s_i;
    etcb_pkg::q30_t c_i;

    if (k == 1) begin : g_seed
      assign ts_i = s11_x;
      assign tc_i = 32'd1 << 30;
      assign x2_i = s11_x2;
      assign s_i  = SC'(s11_x);
      assign c_i  = SC'(32'd1 << 30);
    end else begin : g_chain
      assign ts_i = ts_k[k-1];
      assign tc_i = tc_k[k-1];
      assign x2_i = x2_k[k-1];
      assign s_i  = s_k[k-1];
      assign c_i  = c_k[k-1];
    end

    // product of term and x^2
    logic [63:0]    a_ps;
    logic [63:0]    a_pc;
    logic [31:0]    a_x2;
    etcb_pkg::q30_t a_s;
    etcb_pkg::q30_t a_c;

    always_ff @(posedge clk) begin
      if (en) begin
        a_ps <= 64'(ts_i) * 64'(x2_i);
        a_pc <= 64'(tc_i) * 64'(x2_i);
        a_x2 <= x2_i;
        a_s  <= s_i;
        a_c  <= c_i;
      end
    end

    // quotient estimate by reciprocal
    logic [31:0]    b_ns;
    logic [31:0]    b_nc;
    logic [31:0]    b_qs;
    logic [31:0]    b_qc;
    logic [31:0]    b_x2;
    etcb_pkg::q30_t b_s;
    etcb_pkg::q30_t b_c;
    logic [63:0]    rs_prod;
    logic [63:0]    rc_prod;

    assign rs_prod = 64'(a_ps[61:30]) * 64'(RS);
    assign rc_prod = 64'(a_pc[61:30]) * 64'(RC);

    always_ff @(posedge clk) begin
      if (en) begin
        b_ns <= a_ps[61:30];
        b_nc <= a_pc[61:30];
        b_qs <= rs_prod[63:32];
        b_qc <= rc_prod[63:32];
        b_x2 <= a_x2;
        b_s  <= a_s;
        b_c  <= a_c;
      end
    end

    // exact quotient, then add or subtract the term
    logic [31:0] rem_s;
    logic [31:0] rem_c;
    logic [31:0] q_s;
    logic [31:0] q_c;

    assign rem_s = b_ns - 32'(b_qs * 32'(DS));
    assign rem_c = b_nc - 32'(b_qc * 32'(DC));
    assign q_s   = (rem_s >= 32'(DS)) ? b_qs + 32'd1 : b_qs;
    assign q_c   = (rem_c >= 32'(DC)) ? b_qc + 32'd1 : b_qc;

    always_ff @(posedge clk) begin
      if (en) begin
        ts_k[k] <= q_s;
        tc_k[k] <= q_c;
        x2_k[k] <= b_x2;
        if ((k % 2) == 1) begin
          s_k[k] <= b_s - SC'(q_s);
          c_k[k] <= b_c - SC'(q_c);
        end else begin
          s_k[k] <= b_s + SC'(q_s);
          c_k[k] <= b_c + SC'(q_c);
        end
      end
    end
  end

  // Final stage: quadrant mapping
  always_ff @(posedge clk) begin
    if (en) begin
      case (quad_d[QD-1])
        2'd0: begin
          sin_q <= s_k[NT];
          cos_q <= c_k[NT];
        end
        2'd1: begin
          sin_q <= c_k[NT];
          cos_q <= -s_k[NT];
        end
        2'd2: begin
          sin_q <= -s_k[NT];
          cos_q <= -c_k[NT];
        end
        default: begin
          sin_q <= -c_k[NT];
          cos_q <= s_k[NT];
        end
      endcase
    end
  end

endmodule

@@ rtl/core/euler_to_camera_basis_unit.sv @@
// ----------------------------------------------------------------------------
// euler_to_camera_basis_unit: yaw/pitch/roll to forward, up and right vectors
// Each accepted angle word passes the sine/cosine pipeline and then
// 7 stages of Q30 products, cross product and output rounding.
// Throughput: one word per cycle while the pipeline is not held.
// The whole pipeline holds when the result word is not taken.
// Reset clears only the stage valid bits; no clearing pass.
// ----------------------------------------------------------------------------
module euler_to_camera_basis_unit (
  input  logic        clk,
  input  logic        rst,
  etcb_in_if.sink     angles,
  etcb_out_if.source  basis
);

  localparam int LAT = etcb_pkg::SC_LAT + 7;

  logic           en;
  logic [LAT-1:0] vld;

  // Global stage advance: move when the output slot is free or drained
  assign en           = !vld[LAT-1] || basis.ready;
  assign angles.ready = en;
  assign basis.valid  = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], angles.valid};
    end
  end

  // Sine and cosine of each angle
  etcb_pkg::q30_t sy, cy, sp, cp, sr, cr;

  etcb_sincos u_yaw (
    .clk   (clk),
    .en    (en),
    .angle (angles.yaw_angle),
    .sin_q (sy),
    .cos_q (cy)
  );

  etcb_sincos u_pitch (
    .clk   (clk),
    .en    (en),
    .angle (angles.pitch_angle),
    .sin_q (sp),
    .cos_q (cp)
  );

  etcb_sincos u_roll (
    .clk   (clk),
    .en    (en),
    .angle (angles.roll_angle),
    .sin_q (sr),
    .cos_q (cr)
  );

  // T1: first-level products
  etcb_pkg::prod_t p_sycp, p_cpcy, p_cysr, p_sysp, p_cpcr, p_sysr, p_spcr;
  etcb_pkg::q30_t  t1_sp, t1_cr, t1_cy;

  always_ff @(posedge clk) begin
    if (en) begin
      p_sycp <= sy * cp;
      p_cpcy <= cp * cy;
      p_cysr <= cy * sr;
      p_sysp <= sy * sp;
      p_cpcr <= cp * cr;
      p_sysr <= sy * sr;
      p_spcr <= sp * cr;
      t1_sp  <= sp;
      t1_cr  <= cr;
      t1_cy  <= cy;
    end
  end

  // T2: round to Q30
  etcb_pkg::q30_t t2_fx, t2_fy, t2_fz, t2_a, t2_b, t2_uy, t2_c, t2_d, t2_cr, t2_cy;

  always_ff @(posedge clk) begin
    if (en) begin
      t2_fx <= etcb_pkg::q30_t'(etcb_pkg::rshift(etcb_pkg::wide_t'(p_sycp), 30));
      t2_fz <= -etcb_pkg::q30_t'(etcb_pkg::rshift(etcb_pkg::wide_t'(p_cpcy), 30));
      t2_a  <= etcb_pkg::q30_t'(etcb_pkg::rshift(etcb_pkg::wide_t'(p_cysr), 30));
      t2_b  <= etcb_pkg::q30_t'(etcb_pkg::rshift(etcb_pkg::wide_t'(p_sysp), 30));
      t2_uy <= etcb_pkg::q30_t'(etcb_pkg::rshift(etcb_pkg::wide_t'(p_cpcr), 30));
      t2_c  <= etcb_pkg::q30_t'(etcb_pkg::rshift(etcb_pkg::wide_t'(p_sysr), 30));
      t2_d  <= etcb_pkg::q30_t'(etcb_pkg::rshift(etcb_pkg::wide_t'(p_spcr), 30));
      t2_fy <= t1_sp;
      t2_cr <= t1_cr;
      t2_cy <= t1_cy;
    end
  end

  // T3: triple products
  etcb_pkg::prod_t p_bcr, p_dcy;
  etcb_pkg::q30_t  t3_fx, t3_fy, t3_fz, t3_a, t3_uy, t3_c;

  always_ff @(posedge clk) begin
    if (en) begin
      p_bcr <= t2_b * t2_cr;
      p_dcy <= t2_d * t2_cy;
      t3_fx <= t2_fx;
      t3_fy <= t2_fy;
      t3_fz <= t2_fz;
      t3_a  <= t2_a;
      t3_uy <= t2_uy;
      t3_c  <= t2_c;
    end
  end

  // T4: up vector x and z
  etcb_pkg::q30_t t4_fx, t4_fy, t4_fz, t4_ux, t4_uy, t4_uz;

  always_ff @(posedge clk) begin
    if (en) begin
      t4_ux <= -t3_a - etcb_pkg::q30_t'(etcb_pkg::rshift(etcb_pkg::wide_t'(p_bcr), 30));
      t4_uz <= -t3_c + etcb_pkg::q30_t'(etcb_pkg::rshift(etcb_pkg::wide_t'(p_dcy), 30));
      t4_fx <= t3_fx;
      t4_fy <= t3_fy;
      t4_fz <= t3_fz;
      t4_uy <= t3_uy;
    end
  end

  // T5: cross product terms, forward and up to output format
  etcb_pkg::prod_t p_fyuz, p_fzuy, p_fzux, p_fxuz, p_fxuy, p_fyux;
  logic [15:0] t5_fx, t5_fy, t5_fz, t5_ux, t5_uy, t5_uz;

  always_ff @(posedge clk) begin
    if (en) begin
      p_fyuz <= t4_fy * t4_uz;
      p_fzuy <= t4_fz * t4_uy;
      p_fzux <= t4_fz * t4_ux;
      p_fxuz <= t4_fx * t4_uz;
      p_fxuy <= t4_fx * t4_uy;
      p_fyux <= t4_fy * t4_ux;
      t5_fx  <= etcb_pkg::to_out(etcb_pkg::wide_t'(t4_fx), 30);
      t5_fy  <= etcb_pkg::to_out(etcb_pkg::wide_t'(t4_fy), 30);
      t5_fz  <= etcb_pkg::to_out(etcb_pkg::wide_t'(t4_fz), 30);
      t5_ux  <= etcb_pkg::to_out(etcb_pkg::wide_t'(t4_ux), 30);
      t5_uy  <= etcb_pkg::to_out(etcb_pkg::wide_t'(t4_uy), 30);
      t5_uz  <= etcb_pkg::to_out(etcb_pkg::wide_t'(t4_uz), 30);
    end
  end

  // T6: right vector in Q60
  etcb_pkg::wide_t t6_rx, t6_ry, t6_rz;
  logic [15:0] t6_fx, t6_fy, t6_fz, t6_ux, t6_uy, t6_uz;

  always_ff @(posedge clk) begin
    if (en) begin
      t6_rx <= etcb_pkg::wide_t'(p_fyuz) - etcb_pkg::wide_t'(p_fzuy);
      t6_ry <= etcb_pkg::wide_t'(p_fzux) - etcb_pkg::wide_t'(p_fxuz);
      t6_rz <= etcb_pkg::wide_t'(p_fxuy) - etcb_pkg::wide_t'(p_fyux);
      t6_fx <= t5_fx;
      t6_fy <= t5_fy;
      t6_fz <= t5_fz;
      t6_ux <= t5_ux;
      t6_uy <= t5_uy;
      t6_uz <= t5_uz;
    end
  end

  // T7: output word register
  logic [15:0] o_fx, o_fy, o_fz, o_ux, o_uy, o_uz, o_rx, o_ry, o_rz;

  always_ff @(posedge clk) begin
    if (en) begin
      o_rx <= etcb_pkg::to_out(t6_rx, 60);
      o_ry <= etcb_pkg::to_out(t6_ry, 60);
      o_rz <= etcb_pkg::to_out(t6_rz, 60);
      o_fx <= t6_fx;
      o_fy <= t6_fy;
      o_fz <= t6_fz;
      o_ux <= t6_ux;
      o_uy <= t6_uy;
      o_uz <= t6_uz;
    end
  end

  assign basis.forward_x = o_fx;
  assign basis.forward_y = o_fy;
  assign basis.forward_z = o_fz;
  assign basis.up_x      = o_ux;
  assign basis.up_y      = o_uy;
  assign basis.up_z      = o_uz;
  assign basis.right_x   = o_rx;
  assign basis.right_y   = o_ry;
  assign basis.right_z   = o_rz;

endmodule

@@ tb/euler_to_camera_basis_unit_tb.sv @@
// ----------------------------------------------------------------------------
// euler_to_camera_basis_unit_tb: self-checking bench for the basis unit
// Drives yaw/pitch/roll words and predicts the forward, up and right vectors
// with a fixed-point model kept in the bench. Every result word is compared
// field by field against the oldest prediction. Idle and stall patterns vary
// per phase on both channels.
// ----------------------------------------------------------------------------
module euler_to_camera_basis_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 60;
  localparam longint unsigned PI_Q44 = 64'h3243F6A8885A;

  typedef struct packed {
    logic [15:0] fwd_x, fwd_y, fwd_z;
    logic [15:0] up_x, up_y, up_z;
    logic [15:0] rgt_x, rgt_y, rgt_z;
  } basis_t;

  logic clk;
  logic rst;
  int   src_idle_pct;
  int   snk_idle_pct;
  int   error_count = 0;
  int   cycle_count = 0;
  basis_t expected_basis[$];

  etcb_in_if  angles();
  etcb_out_if basis();

  euler_to_camera_basis_unit uut (
    .clk    (clk),
    .rst    (rst),
    .angles (angles.sink),
    .basis  (basis.source)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Divide by 2^sh, half away from zero
  function automatic longint round_away(input longint v, input int sh);
    longint unsigned mag;
    mag = (v < 0) ? longint'(-v) : v;
    if (sh > 0) mag = (mag + (64'd1 << (sh - 1))) >> sh;
    return (v < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint mul_q30(input longint a, input longint b);
    return round_away(a * b, 30);
  endfunction

  // Round to output format, saturate to +/-1.0, keep 16 bits
  function automatic logic [15:0] out_word(input longint v, input int frac);
    longint r;
    longint lim;
    lim = longint'(1) << etcb_pkg::OUT_FRAC;
    r = round_away(v, frac - etcb_pkg::OUT_FRAC);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r[15:0];
  endfunction

  // Sine and cosine in Q30 of an angle in fractional degrees
  task automatic angle_sin_cos(input logic signed [15:0] ang, output longint sn,
                               output longint cs);
    longint r, q, s, c;
    longint unsigned m, den, x, x2, ts, tc, ns, nc;
    r = longint'(ang) % etcb_pkg::FULL_TURN;
    if (r < 0) r += etcb_pkg::FULL_TURN;
    q = r / etcb_pkg::QUARTER;
    m = r - q * etcb_pkg::QUARTER;
    den = 64'd180 << (14 + etcb_pkg::ANG_FRAC);
    x = (m * PI_Q44 + den / 2) / den;
    x2 = (x * x + (64'd1 << 29)) >> 30;
    ts = x;
    tc = 64'd1 << 30;
    s = ts;
    c = tc;
    for (int k = 1; k <= 8; k++) begin
      ns = 2 * k;
      nc = 2 * k - 1;
      ts = ((ts * x2) >> 30) / (ns * (ns + 1));
      tc = ((tc * x2) >> 30) / (nc * (nc + 1));
      if (k % 2 == 1) begin
        s -= longint'(ts);
        c -= longint'(tc);
      end else begin
        s += longint'(ts);
        c += longint'(tc);
      end
    end
    case (q % 4)
      0: begin sn = s;  cs = c;  end
      1: begin sn = c;  cs = -s; end
      2: begin sn = -s; cs = -c; end
      default: begin sn = -c; cs = s; end
    endcase
  endtask

  // Camera basis from one angle triple
  task automatic predict_basis(input logic signed [15:0] yaw, pitch, roll,
                               output basis_t b);
    longint sy, cy, sp, cp, sr, cr;
    longint fx, fy, fz, ux, uy, uz;
    angle_sin_cos(yaw, sy, cy);
    angle_sin_cos(pitch, sp, cp);
    angle_sin_cos(roll, sr, cr);
    fx = mul_q30(sy, cp);
    fy = sp;
    fz = -mul_q30(cp, cy);
    ux = -mul_q30(cy, sr) - mul_q30(mul_q30(sy, sp), cr);
    uy = mul_q30(cp, cr);
    uz = -mul_q30(sy, sr) + mul_q30(mul_q30(sp, cr), cy);
    b.fwd_x = out_word(fx, 30);
    b.fwd_y = out_word(fy, 30);
    b.fwd_z = out_word(fz, 30);
    b.up_x  = out_word(ux, 30);
    b.up_y  = out_word(uy, 30);
    b.up_z  = out_word(uz, 30);
    b.rgt_x = out_word(fy * uz - fz * uy, 60);
    b.rgt_y = out_word(fz * ux - fx * uz, 60);
    b.rgt_z = out_word(fx * uy - fy * ux, 60);
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want,
             cycle_count);
    error_count++;
  endtask

  // Send one angle word; optional idle gap first, prediction on acceptance
  task automatic send_angles(input logic signed [15:0] yaw, pitch, roll);
    basis_t b;
    if ($urandom_range(99) < src_idle_pct) begin
      angles.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    angles.valid       <= 1'b1;
    angles.yaw_angle   <= yaw;
    angles.pitch_angle <= pitch;
    angles.roll_angle  <= roll;
    @(posedge clk);
    while (!angles.ready) @(posedge clk);
    predict_basis(yaw, pitch, roll, b);
    expected_basis.push_back(b);
  endtask

  // Receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      basis.ready <= 1'b0;
    end else begin
      basis.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Result checker
  always @(posedge clk) begin
    basis_t want;
    if (!rst && basis.valid && basis.ready) begin
      if (expected_basis.size() == 0) begin
        $display("unexpected result word at cycle %0d", cycle_count);
        error_count++;
      end else begin
        want = expected_basis.pop_front();
        if (basis.forward_x !== want.fwd_x) report_mismatch("forward_x", basis.forward_x, want.fwd_x);
        if (basis.forward_y !== want.fwd_y) report_mismatch("forward_y", basis.forward_y, want.fwd_y);
        if (basis.forward_z !== want.fwd_z) report_mismatch("forward_z", basis.forward_z, want.fwd_z);
        if (basis.up_x !== want.up_x) report_mismatch("up_x", basis.up_x, want.up_x);
        if (basis.up_y !== want.up_y) report_mismatch("up_y", basis.up_y, want.up_y);
        if (basis.up_z !== want.up_z) report_mismatch("up_z", basis.up_z, want.up_z);
        if (basis.right_x !== want.rgt_x) report_mismatch("right_x", basis.right_x, want.rgt_x);
        if (basis.right_y !== want.rgt_y) report_mismatch("right_y", basis.right_y, want.rgt_y);
        if (basis.right_z !== want.rgt_z) report_mismatch("right_z", basis.right_z, want.rgt_z);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("euler_to_camera_basis_unit test failed");
      $finish;
    end
  end

  // Extremes, zero, quarter turns and negative angles
  task automatic test_directed_angles();
    logic signed [15:0] pts[12];
    pts = '{16'sd0, 16'sd32767, -16'sd32768, 16'sd5760, 16'sd11520, 16'sd17280,
            16'sd23040, -16'sd5760, -16'sd1, 16'sd1, 16'sd5759, -16'sd23041};
    for (int i = 0; i < 12; i++) send_angles(pts[i], pts[(i + 3) % 12], pts[(i + 7) % 12]);
    send_angles(16'sd2880, 16'sd5760, 16'sd0);
    send_angles(16'sd0, -16'sd5760, 16'sd11520);
    send_angles(-16'sd32768, -16'sd32768, -16'sd32768);
    send_angles(16'sd32767, 16'sd32767, 16'sd32767);
    send_angles(16'sd22, -16'sd11519, 16'sd17281);
  endtask

  function automatic logic signed [15:0] random_angle();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return 16'($urandom());
    if (pick < 90) begin
      return 16'(($urandom_range(11) - 5) * etcb_pkg::QUARTER + $urandom_range(4) - 2);
    end
    return pick[0] ? 16'sd32767 : -16'sd32768;
  endfunction

  task automatic test_random_angles(input int src_pct, input int snk_pct, input int n);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    repeat (n) send_angles(random_angle(), random_angle(), random_angle());
  endtask

  initial begin
    rst = 1'b1;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    angles.valid = 1'b0;
    angles.yaw_angle = '0;
    angles.pitch_angle = '0;
    angles.roll_angle = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    src_idle_pct = 7;
    snk_idle_pct = 73;
    test_directed_angles();
    test_random_angles(7, 73, 450);
    test_random_angles(73, 7, 450);
    test_random_angles(0, 0, 450);
    angles.valid <= 1'b0;
    while (expected_basis.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("euler_to_camera_basis_unit test passed");
    end else begin
      $display("euler_to_camera_basis_unit test failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/etcb_pkg.sv
rtl/core/etcb_if.sv
rtl/core/etcb_sincos.sv
rtl/core/euler_to_camera_basis_unit.sv
tb/euler_to_camera_basis_unit_tb.sv
